// File: design/strhash_pkg.sv
// ----------------------------------------------------------------------------
// strhash_pkg : shared types and constants for the string hash intern table
// Hash constants, fixed result field widths, result beat and FSM state types.
// ----------------------------------------------------------------------------
package strhash_pkg;

  localparam int HASH_W    = 32;
  localparam int CHAR_W    = 8;
  localparam int OUT_IDX_W = 6;
  localparam int OUT_LEN_W = 16;

  localparam logic [HASH_W-1:0] HASH_INIT  = 32'd5381;
  localparam int                HASH_SHIFT = 5;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_LENGTH_BITS = 16;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] entry_index;
    logic                 was_added;
    logic [OUT_LEN_W-1:0] entry_length;
    logic [HASH_W-1:0]    string_hash;
    logic                 table_full;
  } res_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SEARCH
  } tbl_state_t;

endpackage

// File: design/strhash_if.sv
// ----------------------------------------------------------------------------
// strhash_if : valid/ready channels of the string hash intern table
// Character input channel and lookup result channel.
// ----------------------------------------------------------------------------
interface strhash_in_if;
  logic                           valid;
  logic                           ready;
  logic [strhash_pkg::CHAR_W-1:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface strhash_out_if;
  logic                              valid;
  logic                              ready;
  logic [strhash_pkg::OUT_IDX_W-1:0] entry_index;
  logic                              was_added;
  logic [strhash_pkg::OUT_LEN_W-1:0] entry_length;
  logic [strhash_pkg::HASH_W-1:0]    string_hash;
  logic                              table_full;

  modport source (output valid, output entry_index, output was_added,
                  output entry_length, output string_hash, output table_full,
                  input ready);
  modport sink   (input valid, input entry_index, input was_added,
                  input entry_length, input string_hash, input table_full,
                  output ready);
endinterface

// File: design/strhash_acc.sv
// ----------------------------------------------------------------------------
// strhash_acc : running djb2 hash and saturating length
// hash = hash*33 + sign-extended char per beat; both restart on terminator.
// ----------------------------------------------------------------------------
module strhash_acc #(
  parameter int LENGTH_BITS = strhash_pkg::DEF_LENGTH_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic                           clear,
  input  logic [strhash_pkg::CHAR_W-1:0] char_byte,
  output logic [strhash_pkg::HASH_W-1:0] hash,
  output logic [LENGTH_BITS-1:0]         len
);

  localparam int HW = strhash_pkg::HASH_W;
  localparam int CW = strhash_pkg::CHAR_W;

  logic [HW-1:0]          hash_r, hash_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [HW-1:0]          char_sx;

  assign char_sx = {{(HW-CW){char_byte[CW-1]}}, char_byte};

  always_comb begin
    hash_nxt = hash_r;
    len_nxt  = len_r;
    if (clear) begin
      hash_nxt = strhash_pkg::HASH_INIT;
      len_nxt  = '0;
    end else if (step) begin
      hash_nxt = (hash_r << strhash_pkg::HASH_SHIFT) + hash_r + char_sx;
      // length sticks at all-ones
      len_nxt  = (&len_r) ? len_r : len_r + LENGTH_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= strhash_pkg::HASH_INIT;
      len_r  <= '0;
    end else begin
      hash_r <= hash_nxt;
      len_r  <= len_nxt;
    end
  end

  assign hash = hash_r;
  assign len  = len_r;

endmodule

// File: design/strhash_table.sv
// ----------------------------------------------------------------------------
// strhash_table : entry memory, linear search sequencer and result register
// Reads entries 0..count-1 one per cycle, appends on a miss or flags a full table.
// ----------------------------------------------------------------------------
module strhash_table #(
  parameter int TABLE_DEPTH = strhash_pkg::DEF_TABLE_DEPTH,
  parameter int LENGTH_BITS = strhash_pkg::DEF_LENGTH_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [strhash_pkg::HASH_W-1:0] key_hash,
  input  logic [LENGTH_BITS-1:0]         key_len,
  output logic                           idle,
  output logic                           res_valid,
  input  logic                           res_ready,
  output strhash_pkg::res_t              res
);

  localparam int HW    = strhash_pkg::HASH_W;
  localparam int OIW   = strhash_pkg::OUT_IDX_W;
  localparam int OLW   = strhash_pkg::OUT_LEN_W;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = HW + LENGTH_BITS;

  // entry = {length, hash}
  logic [ENT_W-1:0] mem [TABLE_DEPTH];
  logic [ENT_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;

  strhash_pkg::tbl_state_t state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        addr_r, addr_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic [HW-1:0]           key_hash_r, key_hash_nxt;
  logic [LENGTH_BITS-1:0]  key_len_r, key_len_nxt;
  logic                    res_vld_r, res_vld_nxt;
  strhash_pkg::res_t       res_r, res_nxt;
  logic                    load;
  logic                    hit;
  logic                    last;

  assign rd_addr = addr_r[IDX_W-1:0];
  assign hit     = cmp_vld_r && (rd_data_r[HW-1:0] == key_hash_r);
  assign last    = cmp_vld_r && (CNT_W'(cmp_idx_r) == count_r - CNT_W'(1));

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    addr_nxt     = addr_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    key_hash_nxt = key_hash_r;
    key_len_nxt  = key_len_r;
    res_nxt      = res_r;
    load         = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = count_r[IDX_W-1:0];
    wr_data      = {key_len_r, key_hash_r};
    idle         = 1'b0;
    unique case (state_r)
      strhash_pkg::ST_IDLE: begin
        idle = !res_vld_r;
        if (start) begin
          key_hash_nxt = key_hash;
          key_len_nxt  = key_len;
          addr_nxt     = '0;
          state_nxt    = strhash_pkg::ST_SEARCH;
        end
      end
      strhash_pkg::ST_SEARCH: begin
        if (hit) begin
          load                 = 1'b1;
          res_nxt.entry_index  = OIW'(cmp_idx_r);
          res_nxt.was_added    = 1'b0;
          res_nxt.entry_length = OLW'(rd_data_r[ENT_W-1:HW]);
          res_nxt.string_hash  = key_hash_r;
          res_nxt.table_full   = 1'b0;
          state_nxt            = strhash_pkg::ST_IDLE;
        end else if (count_r == '0 || last) begin
          load                = 1'b1;
          res_nxt.string_hash = key_hash_r;
          if (count_r == CNT_W'(TABLE_DEPTH)) begin
            res_nxt.entry_index  = '0;
            res_nxt.was_added    = 1'b0;
            res_nxt.entry_length = '0;
            res_nxt.table_full   = 1'b1;
          end else begin
            wr_en                = 1'b1;
            count_nxt            = count_r + CNT_W'(1);
            res_nxt.entry_index  = OIW'(count_r);
            res_nxt.was_added    = 1'b1;
            res_nxt.entry_length = OLW'(key_len_r);
            res_nxt.table_full   = 1'b0;
          end
          state_nxt = strhash_pkg::ST_IDLE;
        end else if (addr_r < count_r) begin
          // read issued now, compared next cycle
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = addr_r[IDX_W-1:0];
          addr_nxt    = addr_r + CNT_W'(1);
        end
      end
      default: state_nxt = strhash_pkg::ST_IDLE;
    endcase

    res_vld_nxt = res_vld_r;
    if (res_vld_r && res_ready) res_vld_nxt = 1'b0;
    if (load)                   res_vld_nxt = 1'b1;
  end

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= strhash_pkg::ST_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    key_hash_r <= key_hash_nxt;
    key_len_r  <= key_len_nxt;
    res_r      <= res_nxt;
  end

  assign res_valid = res_vld_r;
  assign res       = res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_add_bumps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (load && res_nxt.was_added) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("append without count increment");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && res_r.table_full) |-> (count_r == CNT_W'(TABLE_DEPTH)
                                         && !res_r.was_added))
    else $error("full flag with free entries or with append");

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> idle)
    else $error("search started while busy");

  a_load_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !res_vld_r)
    else $error("result register overwritten");

endmodule

// File: design/string_hash_intern_table_core.sv
// ----------------------------------------------------------------------------
// string_hash_intern_table_core : djb2 string interning table
// Streams characters into a running hash; on the terminator looks the hash
// up in the entry memory and returns the matching or newly appended entry.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat payload                                   | handshake
//  --------+-----+------------------------------------------------+-----------
//  in_ch   | in  | char_byte                                      | valid/ready
//  out_ch  | out | entry_index, was_added, entry_length,          | valid/ready
//          |     | string_hash, table_full                        |
//
//  Cycles: a nonzero character is taken every cycle and gives no result.
//  A terminator is taken only when the search sequencer is idle and the
//  result register is empty; the search then reads the stored entries one
//  per cycle, stopping early on a match, through the one-read-per-cycle
//  port of the entry memory.
//  Characters of the next string keep flowing while a search runs.
//  Reset: synchronous, active low; empties the table and restarts the hash.
//  No memory clearing pass: entries at or above the count are never compared.
//  Stalls: out_ch.ready low holds the result; further terminators wait.
//
module string_hash_intern_table_core #(
  parameter int TABLE_DEPTH = strhash_pkg::DEF_TABLE_DEPTH,
  parameter int LENGTH_BITS = strhash_pkg::DEF_LENGTH_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  strhash_in_if.sink    in_ch,
  strhash_out_if.source out_ch
);

  logic                           in_beat;
  logic                           is_term;
  logic                           tbl_idle;
  logic [strhash_pkg::HASH_W-1:0] run_hash;
  logic [LENGTH_BITS-1:0]         run_len;
  strhash_pkg::res_t              res;

  // zero byte ends the string
  assign is_term     = (in_ch.char_byte == '0);
  // characters never wait; a terminator waits for the table
  assign in_ch.ready = !is_term || tbl_idle;
  assign in_beat     = in_ch.valid && in_ch.ready;

  strhash_acc #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_beat && !is_term),
    .clear     (in_beat && is_term),
    .char_byte (in_ch.char_byte),
    .hash      (run_hash),
    .len       (run_len)
  );

  // key is captured by the table in the same cycle the accumulator restarts
  strhash_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_beat && is_term),
    .key_hash  (run_hash),
    .key_len   (run_len),
    .idle      (tbl_idle),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.entry_index  = res.entry_index;
  assign out_ch.was_added    = res.was_added;
  assign out_ch.entry_length = res.entry_length;
  assign out_ch.string_hash  = res.string_hash;
  assign out_ch.table_full   = res.table_full;

endmodule

// File: bench/string_hash_intern_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_intern_table_core_tb : self-checking bench for the intern table
// Streams strings a character per beat and predicts every lookup result with
// a local djb2 table: matches, appends, hash collisions and a full table.
// Both channels get random idle bursts. A watchdog ends a hung run.
// ----------------------------------------------------------------------------
module string_hash_intern_table_core_tb;

  localparam int CW         = strhash_pkg::CHAR_W;
  localparam int HW         = strhash_pkg::HASH_W;
  localparam int DEPTH      = strhash_pkg::DEF_TABLE_DEPTH;
  localparam int LEN_W      = strhash_pkg::DEF_LENGTH_BITS;
  localparam int RAND_BEATS = 1650;
  localparam int CALM_BEATS = 200;  // last stretch of the feed runs without gaps
  localparam int DRAIN_WAIT = 100;  // longer than a search through all DEPTH entries
  localparam int HANG_LIMIT = 2000;
  localparam logic [CW-1:0]    TERMINATOR = '0;
  localparam logic [LEN_W-1:0] LEN_SAT    = '1;

  logic clk;
  logic rst_n;

  strhash_in_if  in_ch ();
  strhash_out_if out_ch ();

  string_hash_intern_table_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Character beats still to be driven, and lookups predicted but not seen.
  logic [CW-1:0]     char_feed[$];
  strhash_pkg::res_t pending_lookups[$];

  // Words already sent, kept flat so that they can be replayed as matches.
  logic [CW-1:0] word_buf[$];
  logic [CW-1:0] sent_bytes[$];
  int            sent_start[$];
  int            sent_len[$];

  // Local copy of the table.
  logic [HW-1:0]    known_hash[DEPTH];
  logic [LEN_W-1:0] known_len[DEPTH];
  int               known_count;
  logic [HW-1:0]    acc_hash;
  logic [LEN_W-1:0] acc_len;

  int errors;
  int rand_beats;
  int quiet_cycles;
  int in_gap;
  int out_gap;
  logic in_took;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: fold one character into the running hash, or at the terminator
  // look the hash up, appending it if new, and queue the expected lookup.
  // --------------------------------------------------------------------------
  task automatic intern_char(input logic [CW-1:0] ch);
    strhash_pkg::res_t exp_res;
    bit                hit;
    if (ch != TERMINATOR) begin
      // char is added as a signed byte, so the top bit extends
      acc_hash = (acc_hash << strhash_pkg::HASH_SHIFT) + acc_hash
                 + {{(HW-CW){ch[CW-1]}}, ch};
      if (acc_len != LEN_SAT) acc_len = acc_len + 1'b1;
      return;
    end
    hit = 1'b0;
    exp_res = '0;
    exp_res.string_hash = acc_hash;
    // first stored entry with an equal hash wins, even if the text differs
    for (int i = 0; i < known_count; i++) begin
      if (!hit && known_hash[i] == acc_hash) begin
        hit = 1'b1;
        exp_res.entry_index  = strhash_pkg::OUT_IDX_W'(i);
        exp_res.entry_length = strhash_pkg::OUT_LEN_W'(known_len[i]);
      end
    end
    if (!hit) begin
      if (known_count < DEPTH) begin
        known_hash[known_count] = acc_hash;
        known_len[known_count]  = acc_len;
        exp_res.entry_index  = strhash_pkg::OUT_IDX_W'(known_count);
        exp_res.entry_length = strhash_pkg::OUT_LEN_W'(acc_len);
        exp_res.was_added    = 1'b1;
        known_count++;
      end else begin
        // full: index and length read as zero, hash still reported
        exp_res.table_full = 1'b1;
      end
    end
    pending_lookups.push_back(exp_res);
    acc_hash = strhash_pkg::HASH_INIT;
    acc_len  = '0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Sends word_buf plus its terminator; keep = remember it for later replays.
  task automatic commit_word(input bit keep);
    if (keep) begin
      sent_start.push_back(sent_bytes.size());
      sent_len.push_back(word_buf.size());
    end
    foreach (word_buf[i]) begin
      char_feed.push_back(word_buf[i]);
      if (keep) sent_bytes.push_back(word_buf[i]);
    end
    char_feed.push_back(TERMINATOR);
    rand_beats += word_buf.size() + 1;
    word_buf.delete();
  endtask

  task automatic random_word(input int max_len);
    int n;
    n = $urandom_range(1, max_len);
    for (int i = 0; i < n; i++) word_buf.push_back(CW'($urandom_range(1, 255)));
  endtask

  task automatic replay_word();
    int k;
    k = $urandom_range(0, sent_len.size() - 1);
    for (int i = 0; i < sent_len[k]; i++) word_buf.push_back(sent_bytes[sent_start[k] + i]);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: directed words, then a random mix, then drain and report.
  // --------------------------------------------------------------------------
  initial begin
    int pick;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_byte = '0;
    out_ch.ready    = 1'b0;
    errors          = 0;
    known_count     = 0;
    acc_hash        = strhash_pkg::HASH_INIT;
    acc_len         = '0;

    // Empty string: hash 5381, length 0, appended at index 0.
    commit_word(1'b1);
    // "Ez" and "FY" share a djb2 hash, so the second matches the first.
    word_buf = '{8'h45, 8'h7A};
    commit_word(1'b1);
    word_buf = '{8'h46, 8'h59};
    commit_word(1'b1);
    // Bytes with the top bit set subtract from the hash.
    word_buf = '{8'h80, 8'hFF, 8'h80};
    commit_word(1'b1);
    word_buf = '{8'h7F, 8'h01, 8'hFF, 8'h7F};
    commit_word(1'b1);
    // Repeats of earlier words, empty string among them.
    word_buf = '{8'h45, 8'h7A};
    commit_word(1'b1);
    commit_word(1'b1);

    // Random mix: mostly replays and short new words, so the table fills,
    // then keeps both matching and reporting full.
    rand_beats = 0;
    while (rand_beats < RAND_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) replay_word();
      else if (pick < 58) word_buf.delete();
      else if (pick < 92) random_word(8);
      else random_word(40);
      commit_word(1'b1);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (char_feed.size() != 0 || in_ch.valid || pending_lookups.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0 && pending_lookups.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: changes inputs on the falling edge. A beat held on the input
  // channel stays put until taken; gaps only start between beats.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    bit calm;
    calm = char_feed.size() < CALM_BEATS;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
      in_gap  = 0;
      out_gap = 0;
    end else begin
      // character side
      if (in_ch.valid && !in_took) begin
        // still waiting for the beat to be taken
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(1, 4) - 1;
        in_ch.valid <= 1'b0;
      end else if (char_feed.size() != 0) begin
        in_ch.char_byte <= char_feed.pop_front();
        in_ch.valid     <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
      // result side: back-pressure in bursts too
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(1, 4) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples both channels on the rising edge, feeds the predictor
  // and checks each result beat against the oldest expected lookup.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    strhash_pkg::res_t want;
    in_took <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) intern_char(in_ch.char_byte);

      if (out_ch.valid && out_ch.ready) begin
        if (pending_lookups.size() == 0) begin
          $error("result beat with nothing expected: hash %h", out_ch.string_hash);
          errors++;
        end else begin
          want = pending_lookups.pop_front();
          if (out_ch.entry_index !== want.entry_index) begin
            $error("entry_index: expected %0d, got %0d", want.entry_index, out_ch.entry_index);
            errors++;
          end
          if (out_ch.was_added !== want.was_added) begin
            $error("was_added: expected %0b, got %0b", want.was_added, out_ch.was_added);
            errors++;
          end
          if (out_ch.entry_length !== want.entry_length) begin
            $error("entry_length: expected %0d, got %0d", want.entry_length,
                   out_ch.entry_length);
            errors++;
          end
          if (out_ch.string_hash !== want.string_hash) begin
            $error("string_hash: expected %h, got %h", want.string_hash, out_ch.string_hash);
            errors++;
          end
          if (out_ch.table_full !== want.table_full) begin
            $error("table_full: expected %0b, got %0b", want.table_full, out_ch.table_full);
            errors++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too many cycles in a row without a beat on either channel.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
